// File: rtl/asmb_pkg.sv
`timescale 1ns / 1ps
// asmb_pkg: shared constants and the CORDIC angle table for the SRT matrix builder.
// No dependencies.
package asmb_pkg;

	localparam int CORDIC_STEPS    = 24;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int CW              = 34;
	localparam int Q30_FRAC        = 30;
	localparam int MID_DEPTH       = 4;
	localparam int OUT_DEPTH       = 8;
	localparam int IN_W            = 192;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] ROW_0 = 2'd0;
	localparam logic [1:0] ROW_1 = 2'd1;
	localparam logic [1:0] ROW_2 = 2'd2;
	localparam logic [1:0] ROW_3 = 2'd3;

	function automatic logic signed [CW-1:0] atan_turn(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0:  r = 34'sd536870912;
			1:  r = 34'sd316933406;
			2:  r = 34'sd167458907;
			3:  r = 34'sd85004756;
			4:  r = 34'sd42667331;
			5:  r = 34'sd21354465;
			6:  r = 34'sd10679838;
			7:  r = 34'sd5340245;
			8:  r = 34'sd2670163;
			9:  r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			20: r = 34'sd652;
			21: r = 34'sd326;
			22: r = 34'sd163;
			23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/asmb_fifo.sv
`timescale 1ns / 1ps
// asmb_fifo: small register queue between pipeline sections.
// Depends on nothing; DEPTH must be a power of two.
module asmb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CNW-1:0]   count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + CNW'(do_push) - CNW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNW'(DEPTH)) else $error("fifo count beyond depth");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_q == rd_q)) else $error("fifo pointers out of step");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty) else $error("fifo empty after push");

endmodule

// File: rtl/asmb_front.sv
`timescale 1ns / 1ps
// asmb_front: input stage and pipelined CORDIC producing cos/sin for the three axes.
// Depends on asmb_pkg.
module asmb_front #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 16,
	localparam int TW        = FRAC_BITS + 2,
	localparam int ENTRY_W   = asmb_pkg::IN_W + 6 * TW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic signed [31:0]  scale_x,
	input  logic signed [31:0]  scale_y,
	input  logic signed [31:0]  scale_z,
	input  logic [15:0]         angle_x,
	input  logic [15:0]         angle_y,
	input  logic [15:0]         angle_z,
	input  logic signed [31:0]  shift_x,
	input  logic signed [31:0]  shift_y,
	input  logic signed [31:0]  shift_z,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ENTRY_W-1:0]  out_data
);
	localparam int CW  = asmb_pkg::CW;
	localparam int NS  = asmb_pkg::CORDIC_STAGES;
	localparam int SPS = asmb_pkg::STEPS_PER_STAGE;
	localparam int RS  = asmb_pkg::Q30_FRAC - FRAC_BITS;
	localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam logic signed [CW-1:0] HALF_C = CW'(1) <<< (RS - 1);
	localparam logic signed [CW-1:0] ONE_C  = CW'(1) <<< FRAC_BITS;

	logic                        en;
	logic                        v_s [0:NS];
	logic [asmb_pkg::IN_W-1:0]   pay_s [0:NS];
	logic signed [CW-1:0]        x_s [0:NS][0:2];
	logic signed [CW-1:0]        y_s [0:NS][0:2];
	logic signed [CW-1:0]        z_s [0:NS][0:2];
	logic                        flip_s [0:NS][0:2];
	logic signed [CW-1:0]        x_c [1:NS][0:2];
	logic signed [CW-1:0]        y_c [1:NS][0:2];
	logic signed [CW-1:0]        z_c [1:NS][0:2];
	logic                        v_s7;
	logic [asmb_pkg::IN_W-1:0]   pay_s7;
	logic signed [TW-1:0]        c_s7 [0:2];
	logic signed [TW-1:0]        sn_s7 [0:2];
	logic [15:0]                 ang_in [0:2];
	logic [31:0]                 a_c [0:2];
	logic                        flip_c [0:2];
	logic signed [TW-1:0]        c_c [0:2];
	logic signed [TW-1:0]        sn_c [0:2];

	assign en        = !(v_s7 && !out_ready);
	assign full      = !en;
	assign out_valid = v_s7;
	assign ang_in[0] = angle_x;
	assign ang_in[1] = angle_y;
	assign ang_in[2] = angle_z;

	always_comb begin
		logic [31:0] a0;
		for (int l = 0; l < 3; l++) begin
			a0 = ({16'd0, ang_in[l]} & ANG_MASK) << (32 - ANGLE_BITS);
			flip_c[l] = a0[31] ^ a0[30];
			a_c[l] = flip_c[l] ? (a0 - 32'h8000_0000) : a0;
		end
	end

	genvar k, l;
	generate
		for (k = 1; k <= NS; k++) begin : g_stage
			for (l = 0; l < 3; l++) begin : g_lane
				always_comb begin
					logic signed [CW-1:0] xv, yv, zv, dx, dy;
					xv = x_s[k-1][l];
					yv = y_s[k-1][l];
					zv = z_s[k-1][l];
					for (int j = 0; j < SPS; j++) begin
						dx = yv >>> ((k - 1) * SPS + j);
						dy = xv >>> ((k - 1) * SPS + j);
						if (zv >= 0) begin
							xv = xv - dx;
							yv = yv + dy;
							zv = zv - asmb_pkg::atan_turn((k - 1) * SPS + j);
						end else begin
							xv = xv + dx;
							yv = yv - dy;
							zv = zv + asmb_pkg::atan_turn((k - 1) * SPS + j);
						end
					end
					x_c[k][l] = xv;
					y_c[k][l] = yv;
					z_c[k][l] = zv;
				end
			end
		end
	endgenerate

	always_comb begin
		logic signed [CW-1:0] xf, yf, xr, yr;
		for (int m = 0; m < 3; m++) begin
			xf = flip_s[NS][m] ? -x_s[NS][m] : x_s[NS][m];
			yf = flip_s[NS][m] ? -y_s[NS][m] : y_s[NS][m];
			xr = (xf + HALF_C) >>> RS;
			yr = (yf + HALF_C) >>> RS;
			if (xr > ONE_C) xr = ONE_C;
			if (xr < -ONE_C) xr = -ONE_C;
			if (yr > ONE_C) yr = ONE_C;
			if (yr < -ONE_C) yr = -ONE_C;
			c_c[m]  = TW'(xr);
			sn_c[m] = TW'(yr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= NS; s++) v_s[s] <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s[0] <= push;
			for (int s = 1; s <= NS; s++) v_s[s] <= v_s[s-1];
			v_s7 <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s[0] <= {scale_x, scale_y, scale_z, shift_x, shift_y, shift_z};
			for (int m = 0; m < 3; m++) begin
				x_s[0][m]    <= asmb_pkg::CORDIC_GAIN;
				y_s[0][m]    <= '0;
				z_s[0][m]    <= CW'(signed'(a_c[m]));
				flip_s[0][m] <= flip_c[m];
			end
			for (int s = 1; s <= NS; s++) begin
				pay_s[s] <= pay_s[s-1];
				for (int m = 0; m < 3; m++) begin
					x_s[s][m]    <= x_c[s][m];
					y_s[s][m]    <= y_c[s][m];
					z_s[s][m]    <= z_c[s][m];
					flip_s[s][m] <= flip_s[s-1][m];
				end
			end
			pay_s7 <= pay_s[NS];
			for (int m = 0; m < 3; m++) begin
				c_s7[m]  <= c_c[m];
				sn_s7[m] <= sn_c[m];
			end
		end
	end

	assign out_data = {pay_s7, c_s7[0], sn_s7[0], c_s7[1], sn_s7[1], c_s7[2], sn_s7[2]};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("front result changed while stalled");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (out_valid && !out_ready)) else $error("front stalled without cause");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (c_s7[0] <= TW'(ONE_C) && c_s7[0] >= -TW'(ONE_C)))
		else $error("cosine out of range");

endmodule

// File: rtl/asmb_back.sv
`timescale 1ns / 1ps
// asmb_back: row sequencer and matrix pipeline, one row per cycle while queue and credit allow.
// Depends on asmb_pkg; output space is tracked by a credit count.
module asmb_back #(
	parameter int FRAC_BITS = 16,
	localparam int TW       = FRAC_BITS + 2,
	localparam int ENTRY_W  = asmb_pkg::IN_W + 6 * TW,
	localparam int ROW_W    = 3 + 4 * 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic [ENTRY_W-1:0] q_data,
	output logic               row_valid,
	output logic [ROW_W-1:0]   row_data,
	input  logic               out_pop
);
	localparam int PW  = 2 * TW;
	localparam int RW  = TW + 1;
	localparam int SW  = 32 + RW;
	localparam int CRW = $clog2(asmb_pkg::OUT_DEPTH + 1);
	localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] HALF_S = SW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] SAT_HI = SW'(signed'(32'h7FFF_FFFF));
	localparam logic signed [SW-1:0] SAT_LO = SW'(signed'(32'h8000_0000));
	localparam logic [31:0] ONE_W = 32'(64'd1 << FRAC_BITS);

	logic [CRW-1:0] credit_q;
	logic [1:0]     row_q;
	logic           issue;

	logic signed [31:0]   h_sc [0:2];
	logic signed [31:0]   h_sh [0:2];
	logic signed [TW-1:0] h_cx, h_sx, h_cy, h_sy, h_cz, h_sz;

	assign {h_sc[0], h_sc[1], h_sc[2], h_sh[0], h_sh[1], h_sh[2],
		h_cx, h_sx, h_cy, h_sy, h_cz, h_sz} = q_data;

	assign issue = !q_empty && (credit_q != '0);
	assign q_pop = issue && (row_q == asmb_pkg::ROW_3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CRW'(asmb_pkg::OUT_DEPTH);
			row_q    <= asmb_pkg::ROW_0;
		end else begin
			credit_q <= credit_q + CRW'(out_pop) - CRW'(issue);
			if (issue) row_q <= row_q + 2'd1;
		end
	end

	// stage 1: Ry*Rz products
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [1:0]           row_s1, row_s2, row_s3, row_s4, row_s5;
	logic signed [31:0]   sc_s1, sc_s2, sc_s3, sc_s4;
	logic signed [31:0]   sh_s1 [0:2];
	logic signed [31:0]   sh_s2 [0:2];
	logic signed [31:0]   sh_s3 [0:2];
	logic signed [31:0]   sh_s4 [0:2];
	logic signed [TW-1:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	logic signed [PW-1:0] pcc_s1, pcs_s1, psc_s1, pss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= row_q;
		case (row_q)
			asmb_pkg::ROW_0: sc_s1 <= h_sc[0];
			asmb_pkg::ROW_1: sc_s1 <= h_sc[1];
			default:         sc_s1 <= h_sc[2];
		endcase
		for (int j = 0; j < 3; j++) sh_s1[j] <= h_sh[j];
		cx_s1  <= h_cx;
		sx_s1  <= h_sx;
		cy_s1  <= h_cy;
		sy_s1  <= h_sy;
		cz_s1  <= h_cz;
		sz_s1  <= h_sz;
		pcc_s1 <= PW'(h_cy) * PW'(h_cz);
		pcs_s1 <= PW'(h_cy) * PW'(h_sz);
		psc_s1 <= PW'(h_sy) * PW'(h_cz);
		pss_s1 <= PW'(h_sy) * PW'(h_sz);
	end

	// stage 2: round Ry*Rz, form the Rx row products
	logic signed [TW-1:0] r0_s2 [0:2];
	logic signed [PW-1:0] pa_s2 [0:2];
	logic signed [PW-1:0] pb_s2 [0:2];

	always_ff @(posedge clk) begin
		logic signed [TW-1:0] ryz00, ryz01, ryz20, ryz21, ka, kb;
		logic signed [TW-1:0] u [0:2];
		logic signed [TW-1:0] w [0:2];
		ryz00 = TW'((pcc_s1 + HALF_P) >>> FRAC_BITS);
		ryz01 = TW'((pcs_s1 + HALF_P) >>> FRAC_BITS);
		ryz20 = TW'((psc_s1 + HALF_P) >>> FRAC_BITS);
		ryz21 = TW'((pss_s1 + HALF_P) >>> FRAC_BITS);
		case (row_s1)
			asmb_pkg::ROW_2: begin
				ka = -sx_s1;
				kb = cx_s1;
			end
			default: begin
				ka = cx_s1;
				kb = sx_s1;
			end
		endcase
		u[0] = -sz_s1;
		u[1] = cz_s1;
		u[2] = '0;
		w[0] = ryz20;
		w[1] = ryz21;
		w[2] = cy_s1;
		for (int j = 0; j < 3; j++) begin
			pa_s2[j] <= PW'(ka) * PW'(u[j]);
			pb_s2[j] <= PW'(kb) * PW'(w[j]);
			sh_s2[j] <= sh_s1[j];
		end
		r0_s2[0] <= ryz00;
		r0_s2[1] <= ryz01;
		r0_s2[2] <= -sy_s1;
		row_s2   <= row_s1;
		sc_s2    <= sc_s1;
	end

	// stage 3: rotation row element
	logic signed [RW-1:0] r_s3 [0:2];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (row_s2 == asmb_pkg::ROW_0) begin
				r_s3[j] <= RW'(r0_s2[j]);
			end else begin
				r_s3[j] <= RW'((pa_s2[j] + pb_s2[j] + HALF_P) >>> FRAC_BITS);
			end
			sh_s3[j] <= sh_s2[j];
		end
		row_s3 <= row_s2;
		sc_s3  <= sc_s2;
	end

	// stage 4: apply scale
	logic signed [SW-1:0] p_s4 [0:2];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			p_s4[j]  <= SW'(sc_s3) * SW'(r_s3[j]);
			sh_s4[j] <= sh_s3[j];
		end
		row_s4 <= row_s3;
		sc_s4  <= sc_s3;
	end

	// stage 5: round, saturate, assemble row
	logic [31:0] e_s5 [0:3];

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] rv;
		for (int j = 0; j < 3; j++) begin
			rv = (p_s4[j] + HALF_S) >>> FRAC_BITS;
			if (row_s4 == asmb_pkg::ROW_3) e_s5[j] <= sh_s4[j];
			else if (rv > SAT_HI) e_s5[j] <= 32'h7FFF_FFFF;
			else if (rv < SAT_LO) e_s5[j] <= 32'h8000_0000;
			else e_s5[j] <= 32'(rv);
		end
		e_s5[3] <= (row_s4 == asmb_pkg::ROW_3) ? ONE_W : 32'd0;
		row_s5  <= row_s4;
	end

	assign row_valid = v_s5;
	assign row_data  = {row_s5, (row_s5 == asmb_pkg::ROW_3),
		e_s5[0], e_s5[1], e_s5[2], e_s5[3]};

	a_credit_max: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CRW'(asmb_pkg::OUT_DEPTH)) else $error("credit overrun");
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && row_s5 == asmb_pkg::ROW_0) |-> ($past(row_s5) == asmb_pkg::ROW_3
		|| !$past(v_s5))) else $error("row order broken");
	a_row_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && row_q != asmb_pkg::ROW_3) |=> !q_pop || issue)
		else $error("sequencer dropped a transaction");

endmodule

// File: rtl/affine_srt_matrix_builder_top.sv
`timescale 1ns / 1ps
// Accepted transactions pass the front CORDIC, mid queue, back stages and output queue.
// Back section: one row per cycle while the mid queue is not empty and credit remains.
// Front CORDIC takes a transaction each cycle unless stalled; a 4-entry queue buffers it.
// Reset: arst_n clears queues, pipeline valids and row counter, and refills credits.
// Depends on asmb_pkg, asmb_front, asmb_fifo, asmb_back.
module affine_srt_matrix_builder_top #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] scale_x,
	input  logic signed [31:0] scale_y,
	input  logic signed [31:0] scale_z,
	input  logic [15:0]        angle_x,
	input  logic [15:0]        angle_y,
	input  logic [15:0]        angle_z,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         row_index,
	output logic signed [31:0] elem0,
	output logic signed [31:0] elem1,
	output logic signed [31:0] elem2,
	output logic signed [31:0] elem3,
	output logic               last_row
);
	localparam int TW      = FRAC_BITS + 2;
	localparam int ENTRY_W = asmb_pkg::IN_W + 6 * TW;
	localparam int ROW_W   = 3 + 4 * 32;

	logic               f_valid, mid_full, mid_empty, mid_pop;
	logic [ENTRY_W-1:0] f_data, mid_data;
	logic               row_valid, out_full, out_pop;
	logic [ROW_W-1:0]   row_data, out_data;

	asmb_front #(.FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.shift_x(shift_x), .shift_y(shift_y), .shift_z(shift_z),
		.out_valid(f_valid), .out_ready(!mid_full), .out_data(f_data)
	);

	asmb_fifo #(.WIDTH(ENTRY_W), .DEPTH(asmb_pkg::MID_DEPTH)) u_mid (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .full(mid_full), .wdata(f_data),
		.pop(mid_pop), .empty(mid_empty), .rdata(mid_data)
	);

	asmb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(mid_empty), .q_pop(mid_pop),
		.q_data(mid_data), .row_valid(row_valid), .row_data(row_data),
		.out_pop(out_pop)
	);

	asmb_fifo #(.WIDTH(ROW_W), .DEPTH(asmb_pkg::OUT_DEPTH)) u_out (
		.clk(clk), .arst_n(arst_n), .push(row_valid), .full(out_full), .wdata(row_data),
		.pop(pop), .empty(empty), .rdata(out_data)
	);

	assign out_pop = pop && !empty;
	assign {row_index, last_row, elem0, elem1, elem2, elem3} = out_data;

	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(row_valid && out_full)) else $error("row transaction lost");
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_row == (row_index == asmb_pkg::ROW_3)))
		else $error("last flag mismatch");
	a_row3_one: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && row_index != asmb_pkg::ROW_3) |-> (elem3 == 32'sd0))
		else $error("column 3 nonzero");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for affine_srt_matrix_builder_top (scale/rotate/translate matrix).
// Depends on asmb_pkg and the block RTL; predicts each row with an in-bench CORDIC and matrix model.
module tb_top;

	typedef struct {
		logic [1:0]         row;
		logic signed [31:0] e0, e1, e2, e3;
		logic               lst;
	} row_t;

	localparam int FRAC = 16;
	localparam longint ONE = 64'sd1 <<< FRAC;
	localparam longint LIMIT = 400000;

	logic clk, arst_n, push, full, empty, pop;
	logic signed [31:0] scale_x, scale_y, scale_z, shift_x, shift_y, shift_z;
	logic [15:0] angle_x, angle_y, angle_z;
	logic [1:0] row_index;
	logic signed [31:0] elem0, elem1, elem2, elem3;
	logic last_row;

	row_t rows_due[$];
	int errors = 0;
	int sent = 0;
	int rows_seen = 0;
	longint cycles = 0;

	affine_srt_matrix_builder_top u_top (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("affine_srt_matrix_builder_top regression: fail");
			$finish;
		end
	end

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rnd(longint p, int s);
		return asr(p + (64'sd1 <<< (s - 1)), s);
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint atan_step(int i);
		longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] a;
		longint x, y, z, dx, dy;
		bit flip;
		a = {ang, 16'h0};
		x = 652032874;
		y = 0;
		flip = 0;
		if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
			a = a - 32'h8000_0000;
			flip = 1;
		end
		z = longint'($signed(a));
		for (int i = 0; i < 24; i++) begin
			dx = asr(y, i);
			dy = asr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		x = rnd(x, 30 - FRAC);
		y = rnd(y, 30 - FRAC);
		if (x > ONE) x = ONE;
		if (x < -ONE) x = -ONE;
		if (y > ONE) y = ONE;
		if (y < -ONE) y = -ONE;
		c = x;
		s = y;
	endtask

	task automatic mat_mul(input longint a[3][3], input longint b[3][3], output longint r[3][3]);
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
				r[i][j] = sat(rnd(acc, FRAC));
			end
	endtask

	task automatic predict_rows(input logic signed [31:0] sc[3], input logic [15:0] an[3],
			input logic signed [31:0] sh[3]);
		longint cx, sx, cy, sy, cz, sz;
		longint rx[3][3], ry[3][3], rz[3][3], ryz[3][3], r[3][3];
		longint w[3];
		row_t e;
		sin_cos(an[0], cx, sx);
		sin_cos(an[1], cy, sy);
		sin_cos(an[2], cz, sz);
		rx = '{'{ONE, 0, 0}, '{0, cx, sx}, '{0, -sx, cx}};
		ry = '{'{cy, 0, -sy}, '{0, ONE, 0}, '{sy, 0, cy}};
		rz = '{'{cz, sz, 0}, '{-sz, cz, 0}, '{0, 0, ONE}};
		mat_mul(ry, rz, ryz);
		mat_mul(rx, ryz, r);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) w[j] = sat(rnd(longint'(sc[i]) * r[i][j], FRAC));
			e.row = i[1:0];
			e.e0 = 32'(w[0]); e.e1 = 32'(w[1]); e.e2 = 32'(w[2]); e.e3 = '0;
			e.lst = 1'b0;
			rows_due.push_back(e);
		end
		e.row = asmb_pkg::ROW_3;
		e.e0 = sh[0]; e.e1 = sh[1]; e.e2 = sh[2]; e.e3 = ONE[31:0];
		e.lst = 1'b1;
		rows_due.push_back(e);
	endtask

	task automatic send_transform(input logic signed [31:0] sc[3], input logic [15:0] an[3],
			input logic signed [31:0] sh[3]);
		repeat ($urandom_range(0, 4)) @(negedge clk);
		{scale_x, scale_y, scale_z} = {sc[0], sc[1], sc[2]};
		{angle_x, angle_y, angle_z} = {an[0], an[1], an[2]};
		{shift_x, shift_y, shift_z} = {sh[0], sh[1], sh[2]};
		push = 1;
		do @(posedge clk); while (full);
		predict_rows(sc, an, sh);
		sent++;
		@(negedge clk);
		push = 0;
	endtask

	function automatic logic signed [31:0] rand_scale();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
		endcase
	endfunction

	// Pop side: random stall per row, compare against the oldest prediction.
	initial begin
		row_t e;
		pop = 0;
		forever begin
			@(negedge clk);
			pop = 0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
			pop = 1;
			do @(posedge clk); while (empty);
			rows_seen++;
			if (rows_due.size() == 0) begin
				$error("row with no transaction pending: row_index=%0d", row_index);
				errors++;
			end else begin
				e = rows_due.pop_front();
				if (row_index !== e.row) begin
					$error("row_index exp %0d got %0d", e.row, row_index); errors++;
				end
				if (elem0 !== e.e0) begin
					$error("elem0 exp %0d got %0d", e.e0, elem0); errors++;
				end
				if (elem1 !== e.e1) begin
					$error("elem1 exp %0d got %0d", e.e1, elem1); errors++;
				end
				if (elem2 !== e.e2) begin
					$error("elem2 exp %0d got %0d", e.e2, elem2); errors++;
				end
				if (elem3 !== e.e3) begin
					$error("elem3 exp %0d got %0d", e.e3, elem3); errors++;
				end
				if (last_row !== e.lst) begin
					$error("last_row exp %0d got %0d", e.lst, last_row); errors++;
				end
			end
		end
	end

	task automatic test_identity_and_extremes();
		logic signed [31:0] sc[3], sh[3];
		logic [15:0] an[3];
		sc = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000};
		an = '{16'h0, 16'h0, 16'h0};
		sh = '{0, 0, 0};
		send_transform(sc, an, sh);
		sc = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0};
		sh = '{32'sh7fff_ffff, 32'sh8000_0000, -1};
		an = '{16'hffff, 16'h0, 16'h8000};
		send_transform(sc, an, sh);
		sc = '{32'sh8000_0000, 32'sh7fff_ffff, -1};
		sh = '{32'sh8000_0000, 32'sh7fff_ffff, 1};
		an = '{16'h2000, 16'hffff, 16'hffff};
		send_transform(sc, an, sh);
		sc = '{-1, -1, -1};
		sh = '{-1, -1, -1};
		an = '{16'hffff, 16'hffff, 16'hffff};
		send_transform(sc, an, sh);
	endtask

	task automatic test_quadrant_angles();
		logic signed [31:0] sc[3], sh[3];
		logic [15:0] quad[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
			16'h3fff, 16'h4001, 16'hbfff, 16'hc001};
		logic [15:0] an[3];
		for (int i = 0; i < 8; i++) begin
			sc = '{32'sh0002_0000, 32'sh0001_8000, -32'sh0001_0000};
			sh = '{32'sh0000_1234, -32'sh0010_0000, 32'sh5555_5555};
			an = '{quad[i], quad[(i + 3) % 8], quad[(i + 5) % 8]};
			send_transform(sc, an, sh);
		end
	endtask

	task automatic test_saturation();
		logic signed [31:0] sc[3], sh[3];
		logic [15:0] an[3];
		for (int i = 0; i < 4; i++) begin
			sc = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
			an = '{16'(16'h2000 * i), 16'(16'h1000 + 16'h2000 * i), 16'(16'h6000 * i)};
			sh = '{$urandom, $urandom, $urandom};
			send_transform(sc, an, sh);
		end
	endtask

	task automatic test_random_transforms(input int n);
		logic signed [31:0] sc[3], sh[3];
		logic [15:0] an[3];
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < 3; i++) begin
				sc[i] = rand_scale();
				an[i] = 16'($urandom_range(0, 65535));
				sh[i] = $urandom;
			end
			send_transform(sc, an, sh);
		end
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		{scale_x, scale_y, scale_z, shift_x, shift_y, shift_z} = '0;
		{angle_x, angle_y, angle_z} = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_identity_and_extremes();
		test_quadrant_angles();
		test_saturation();
		test_random_transforms(364);
		while (rows_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d transforms and %0d rows: identity, quadrant angles,", sent, rows_seen);
		$display("scale saturation and random scale/angle/shift with random stalls");
		if (errors == 0)
			$display("affine_srt_matrix_builder_top regression: pass");
		else
			$display("affine_srt_matrix_builder_top regression: fail");
		$finish;
	end
endmodule
